// ===== rtl/core/sjt_pkg.sv =====
// ----------------------------------------------------------------------------
// sjt_pkg: shared types and constants for the smoothstep joint trajectory
// Angle format, per-joint state entry, channel payloads and divider link.
// ----------------------------------------------------------------------------
`default_nettype none

package sjt_pkg;

  localparam int ANGLE_FRAC_BITS = 4;
  localparam int NUM_JOINTS      = 6;
  localparam int JW              = $clog2(NUM_JOINTS);
  localparam int DIV_STEPS       = 16;
  localparam int DEG90           = 90 << ANGLE_FRAC_BITS;
  localparam int ANG_HI          = ((180 << ANGLE_FRAC_BITS) > 32767) ? 32767
                                   : (180 << ANGLE_FRAC_BITS);
  localparam int STEP_SHIFT      = ANGLE_FRAC_BITS + 8;

  localparam logic [15:0] MIN_MOVE_MS    = 16'd500;
  localparam logic [15:0] TOGGLE_MOVE_MS = 16'd1000;
  localparam logic [15:0] RESET_MOVE_MS  = 16'd1000;
  localparam logic [15:0] SPD_RESET      = 16'd2273;

  // Command kinds
  typedef enum logic [1:0] {
    KIND_MOVE   = 2'd0,
    KIND_TOGGLE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [15:0] target_j1;
    logic signed [15:0] target_j2;
    logic signed [15:0] target_j3;
    logic signed [15:0] target_j4;
    logic signed [15:0] target_j5;
    logic signed [15:0] target_j6;
    logic        [15:0] duration_ms;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] angle_j1;
    logic signed [15:0] angle_j2;
    logic signed [15:0] angle_j3;
    logic signed [15:0] angle_j4;
    logic signed [15:0] angle_j5;
    logic signed [15:0] angle_j6;
    logic signed [23:0] stepper_steps;
    logic               moving;
    logic               finished;
  } res_t;

  // One joint's row in the state memory
  typedef struct packed {
    logic signed [15:0] start;
    logic signed [15:0] goal;
    logic signed [15:0] now;
  } ent_t;

  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
  } div_rsp_t;

  // Row contents after reset
  function automatic ent_t reset_entry(input logic [JW-1:0] j);
    ent_t e;
    e.start = 16'(DEG90);
    e.goal  = 16'(DEG90);
    e.now   = (j == '0) ? 16'sd0 : 16'(DEG90);
    return e;
  endfunction

  // Gripper offset per joint, in angle units
  function automatic logic [15:0] joint_offset(input logic [JW-1:0] j);
    logic [15:0] o;
    case (j)
      JW'(1):  o = 16'(20 << ANGLE_FRAC_BITS);
      JW'(2):  o = 16'(30 << ANGLE_FRAC_BITS);
      JW'(3):  o = 16'(40 << ANGLE_FRAC_BITS);
      JW'(4):  o = 16'(50 << ANGLE_FRAC_BITS);
      JW'(5):  o = 16'(70 << ANGLE_FRAC_BITS);
      default: o = 16'd0;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sjt_if.sv =====
// ----------------------------------------------------------------------------
// sjt_if: valid/ready channels for command beats and result beats
// One interface per direction, each with a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface sjt_cmd_if import sjt_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sjt_res_if import sjt_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sjt_div.sv =====
// ----------------------------------------------------------------------------
// sjt_div: restoring divider for the profile fraction
// Computes floor(num * 2^16 / den) for num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sjt_div import sjt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [3:0]  cnt;
  logic [15:0] rem;
  logic [15:0] den;
  logic [15:0] quo;
  logic [16:0] trial;
  logic        fits;

  // Shift one bit of the partial remainder and try the subtract
  assign trial = {rem, 1'b0};
  assign fits  = (trial >= {1'b0, den});

  // Iterate one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= req.num;
        den  <= req.den;
        quo  <= '0;
      end else if (busy) begin
        rem <= fits ? 16'(trial - {1'b0, den}) : trial[15:0];
        quo <= {quo[14:0], fits};
        cnt <= cnt + 4'd1;
        if (cnt == 4'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire

// ===== rtl/core/smoothstep_joint_trajectory.sv =====
// Flow: a move, a toggle or a tick while idle goes from the command beat
//   straight to the joint sweep; a tick during a move first runs the divide
//   and the smoothstep stages, and the tick that ends the move skips the divide.
// Throughput: one command at a time, set by the 16-step divider and the
//   joint sweep through the single-port state memory.
// Reset: control clears at once; joint rows read as reset angles until
//   written (per-row valid bits), so no clearing pass is needed.
// ----------------------------------------------------------------------------
// smoothstep_joint_trajectory: six-joint S-curve trajectory generator
// Keeps start/goal/current angles per joint in a synchronous memory and
// updates them row by row on move, gripper toggle and 1 ms tick commands.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothstep_joint_trajectory import sjt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  sjt_cmd_if.sink     cmd,
  sjt_res_if.source   res
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SQ, S_KM, S_KL, S_RD, S_EX, S_WB, S_STP, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_MOVE, OP_TOGGLE, OP_TICK, OP_HOLD
  } op_t;

  localparam logic [17:0]        K_THREE  = 18'(3 * 65536);
  localparam logic [16:0]        F_ONE    = 17'h10000;
  localparam logic signed [17:0] CLAMP_HI = 18'(ANG_HI);
  localparam logic signed [37:0] STEP_MAX = 38'sd8388607;
  localparam logic signed [37:0] STEP_MIN = -38'sd8388608;
  localparam logic signed [37:0] STEP_RND = 38'((1 << STEP_SHIFT) - 1);

  state_t             state;
  op_t                op;
  logic [JW-1:0]      jnt;
  logic signed [15:0] tgt [NUM_JOINTS];
  logic signed [15:0] ang [NUM_JOINTS];
  logic [15:0]        elapsed;
  logic [15:0]        move_time;
  logic [15:0]        spd;
  logic               in_motion;
  logic               gripper_closed;
  logic               close_dir;
  logic               fin;
  logic [16:0]        f;
  logic [16:0]        k;
  logic signed [37:0] prod;
  ent_t               ent_q;
  logic               res_valid;
  res_t               res_q;

  // State memory and its row valid bits
  ent_t                  mem [NUM_JOINTS];
  logic [NUM_JOINTS-1:0] vld;
  ent_t                  rd_q;
  logic                  rd_vld_q;

  logic               mem_we;
  ent_t               mem_wd;
  ent_t               ent_cur;
  logic               step_done;
  logic signed [15:0] ang_new;
  logic signed [18:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [16:0] span;
  logic signed [17:0] tog_t;
  logic signed [15:0] tog_goal;
  logic signed [15:0] now_wb;
  logic signed [37:0] step_adj;
  logic signed [37:0] step_shr;
  logic signed [23:0] steps;
  logic [15:0]        einc;
  logic               cmd_fire;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign res.valid = res_valid;
  assign res.data  = res_q;

  assign einc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;

  // Start the fraction divide on a tick that does not end the move
  always_comb begin
    div_req.start = cmd_fire && (cmd.data.kind == KIND_TICK) && in_motion
                    && (einc < move_time);
    div_req.num   = einc;
    div_req.den   = move_time;
  end

  sjt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Row read with reset fallback
  assign ent_cur = rd_vld_q ? rd_q : reset_entry(jnt);
  assign span    = {ent_cur.goal[15], ent_cur.goal} - {ent_cur.start[15], ent_cur.start};

  // Gripper goal: offset from the current angle, clamp to the joint range
  always_comb begin
    if (close_dir) begin
      tog_t = 18'(ent_cur.now) + 18'(signed'({2'b00, joint_offset(jnt)}));
    end else begin
      tog_t = 18'(ent_cur.now) - 18'(signed'({2'b00, joint_offset(jnt)}));
    end
    if (tog_t > CLAMP_HI) begin
      tog_goal = CLAMP_HI[15:0];
    end else if (tog_t < 18'sd0) begin
      tog_goal = 16'sd0;
    end else begin
      tog_goal = tog_t[15:0];
    end
  end

  // Interpolated angle: start + floor(span * k / 2^16)
  assign now_wb = 16'(17'(ent_q.start) + prod[32:16]);

  // Row write-back and staged angle per joint
  always_comb begin
    mem_we    = 1'b0;
    mem_wd    = ent_cur;
    ang_new   = ent_cur.now;
    step_done = 1'b0;
    if (state == S_EX) begin
      case (op)
        OP_MOVE: begin
          mem_we    = 1'b1;
          mem_wd    = '{start: ent_cur.now, goal: tgt[jnt], now: ent_cur.now};
          step_done = 1'b1;
        end
        OP_TOGGLE: begin
          mem_we    = 1'b1;
          mem_wd    = '{start: ent_cur.now,
                        goal:  (jnt == '0) ? ent_cur.goal : tog_goal,
                        now:   ent_cur.now};
          step_done = 1'b1;
        end
        OP_TICK: begin
          step_done = 1'b0;
        end
        default: begin
          step_done = 1'b1;
        end
      endcase
    end else if (state == S_WB) begin
      mem_we    = 1'b1;
      mem_wd    = '{start: ent_q.start, goal: ent_q.goal, now: now_wb};
      ang_new   = now_wb;
      step_done = 1'b1;
    end
  end

  // Shared multiplier operands
  always_comb begin
    unique case (state)
      S_SQ: begin
        mul_a = {2'b00, f};
        mul_b = {2'b00, f};
      end
      S_KM: begin
        mul_a = {2'b00, prod[32:16]};
        mul_b = {1'b0, K_THREE - {f, 1'b0}};
      end
      S_EX: begin
        mul_a = 19'(span);
        mul_b = {2'b00, k};
      end
      // Hold the step product while the result waits for its slot
      S_STP, S_OUT: begin
        mul_a = 19'(ang[0]);
        mul_b = {3'b000, spd};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Step count: truncate toward zero, saturate to 24 bits
  always_comb begin
    step_adj = prod + (prod[37] ? STEP_RND : 38'sd0);
    step_shr = step_adj >>> STEP_SHIFT;
    if (step_shr > STEP_MAX) begin
      steps = STEP_MAX[23:0];
    end else if (step_shr < STEP_MIN) begin
      steps = STEP_MIN[23:0];
    end else begin
      steps = step_shr[23:0];
    end
  end

  // State memory: write-back and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[jnt] <= mem_wd;
    end
    rd_q <= mem[jnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[jnt] <= 1'b1;
      end
      rd_vld_q <= vld[jnt];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      spd <= SPD_RESET;
    end else if (cfg_we) begin
      spd <= cfg_wdata;
    end
  end

  // Sequencer: accept, divide, smoothstep, joint sweep, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      op             <= OP_HOLD;
      jnt            <= '0;
      elapsed        <= '0;
      move_time      <= RESET_MOVE_MS;
      in_motion      <= 1'b0;
      gripper_closed <= 1'b0;
      close_dir      <= 1'b0;
      fin            <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            jnt    <= '0;
            fin    <= 1'b0;
            tgt[0] <= cmd.data.target_j1;
            tgt[1] <= cmd.data.target_j2;
            tgt[2] <= cmd.data.target_j3;
            tgt[3] <= cmd.data.target_j4;
            tgt[4] <= cmd.data.target_j5;
            tgt[5] <= cmd.data.target_j6;
            state  <= S_RD;
            case (cmd.data.kind)
              KIND_MOVE: begin
                op        <= OP_MOVE;
                elapsed   <= '0;
                in_motion <= 1'b1;
                move_time <= (cmd.data.duration_ms < MIN_MOVE_MS) ? MIN_MOVE_MS
                             : cmd.data.duration_ms;
              end
              KIND_TOGGLE: begin
                op             <= OP_TOGGLE;
                elapsed        <= '0;
                in_motion      <= 1'b1;
                move_time      <= TOGGLE_MOVE_MS;
                close_dir      <= gripper_closed;
                gripper_closed <= !gripper_closed;
              end
              KIND_TICK: begin
                if (in_motion) begin
                  op      <= OP_TICK;
                  elapsed <= einc;
                  if (einc >= move_time) begin
                    f         <= F_ONE;
                    in_motion <= 1'b0;
                    fin       <= 1'b1;
                    state     <= S_SQ;
                  end else begin
                    state <= S_DIV;
                  end
                end else begin
                  op <= OP_HOLD;
                end
              end
              default: begin
                op <= OP_HOLD;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            f     <= {1'b0, div_rsp.quo};
            state <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_KM;
        end
        S_KM: begin
          state <= S_KL;
        end
        S_KL: begin
          k     <= prod[32:16];
          state <= S_RD;
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX, S_WB: begin
          if (state == S_EX) begin
            ent_q <= ent_cur;
            if (!step_done) begin
              state <= S_WB;
            end
          end
          if (step_done) begin
            ang[jnt] <= ang_new;
            if (jnt == JW'(NUM_JOINTS - 1)) begin
              state <= S_STP;
            end else begin
              jnt   <= jnt + JW'(1);
              state <= S_RD;
            end
          end
        end
        S_STP: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold until the result register is free
          if (!res_valid || res.ready) begin
            res_valid           <= 1'b1;
            res_q.angle_j1      <= ang[0];
            res_q.angle_j2      <= ang[1];
            res_q.angle_j3      <= ang[2];
            res_q.angle_j4      <= ang[3];
            res_q.angle_j5      <= ang[4];
            res_q.angle_j6      <= ang[5];
            res_q.stepper_steps <= steps;
            res_q.moving        <= in_motion;
            res_q.finished      <= fin;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sjt_checker.sv =====
// ----------------------------------------------------------------------------
// sjt_checker: port-level checks for the trajectory generator
// Watches the command and result channels; attached to the top by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sjt_checker import sjt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input res_t res_data
);

  // A stalled result beat holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  // One command in flight: ready drops after a command beat
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while another is in flight");

  // The tick that ends a move reports the move as stopped
  a_fin_stop: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.finished && res_data.moving))
    else $error("finished while still moving");

  // Zero joint 1 angle gives zero steps
  a_zero_steps: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.angle_j1 == 16'sd0) |-> res_data.stepper_steps == 24'sd0)
    else $error("step count nonzero at zero angle");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind smoothstep_joint_trajectory sjt_checker u_sjt_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);

`default_nettype wire
